/* rtl/plst_pkg.sv */
`timescale 1ns / 1ps
package plst_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int CNT_W = 7;
  localparam int POS_W = 8;

  // action codes
  localparam logic [2:0] ACT_INS_TAIL = 3'd0;
  localparam logic [2:0] ACT_INS_HEAD = 3'd1;
  localparam logic [2:0] ACT_INS_POS  = 3'd2;
  localparam logic [2:0] ACT_DEL_TAIL = 3'd3;
  localparam logic [2:0] ACT_DEL_HEAD = 3'd4;
  localparam logic [2:0] ACT_DEL_POS  = 3'd5;
  localparam logic [2:0] ACT_READ     = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {OP_INSERT, OP_DELETE, OP_READ, OP_BAD} op_t;
  typedef enum logic [1:0] {AT_TAIL, AT_HEAD, AT_POS} where_t;
  typedef enum logic [1:0] {S_IDLE, S_INS, S_DEL, S_READ} back_state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [6:0]         element_position;
    logic [6:0]         count;
    logic               last;
  } out_word_t;

  // decoded command as it sits in the queue
  typedef struct packed {
    op_t                op;
    where_t             where;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } cmd_t;

  // handshake between queue and back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

/* rtl/positional_list_store_unit.sv */
`timescale 1ns / 1ps
// channel   ports                       direction  handshake
// command   start, busy, in_cmd         in         taken when start high and busy low
// result    out_valid, out_res          out        one cycle per word, strobed by out_valid
//
// after dispatch, insert shifts elements from the tail to the index and writes the value,
// delete shifts those behind the index toward the tail, read-out sends them from the head,
// rejected commands answer from dispatch; the single store port (one write, one read a
// cycle) paces this. busy rises only when the two-entry command queue is full
// synchronous active-low reset empties the list and the queue; the store is not cleared
// results cannot be held off by the receiver, every word goes out on its strobe cycle
module positional_list_store_unit
  import plst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_cmd,
  output logic      out_valid,
  output out_word_t out_res
);

  // front end decode to queue
  logic    push;
  cmd_t    push_cmd;

  // queue to back end
  q_stat_t q_stat;
  cmd_t    head_cmd;
  logic    pop;

  // decode action into operation and target
  plst_front u_front (
    .start  (start),
    .q_full (q_stat.full),
    .in_cmd (in_cmd),
    .push   (push),
    .cmd    (push_cmd)
  );

  // short queue so the front keeps taking words while the back shifts
  plst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .stat     (q_stat),
    .head     (head_cmd)
  );

  // list store, shift sequencer and result register
  plst_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign busy = q_stat.full;

endmodule

/* rtl/plst_front.sv */
`timescale 1ns / 1ps
module plst_front
  import plst_pkg::*;
(
  input  logic     start,
  input  logic     q_full,
  input  in_word_t in_cmd,
  output logic     push,
  output cmd_t     cmd
);

  assign push = start && !q_full;

  always_comb begin
    cmd.position = in_cmd.position;
    cmd.value    = in_cmd.value;
    cmd.op       = OP_BAD;
    cmd.where    = AT_TAIL;
    case (in_cmd.action)
      ACT_INS_TAIL: begin
        cmd.op = OP_INSERT;
      end
      ACT_INS_HEAD: begin
        cmd.op    = OP_INSERT;
        cmd.where = AT_HEAD;
      end
      ACT_INS_POS: begin
        cmd.op    = OP_INSERT;
        cmd.where = AT_POS;
      end
      ACT_DEL_TAIL: begin
        cmd.op = OP_DELETE;
      end
      ACT_DEL_HEAD: begin
        cmd.op    = OP_DELETE;
        cmd.where = AT_HEAD;
      end
      ACT_DEL_POS: begin
        cmd.op    = OP_DELETE;
        cmd.where = AT_POS;
      end
      ACT_READ: begin
        cmd.op = OP_READ;
      end
      default: begin
        cmd.op = OP_BAD;
      end
    endcase
  end

endmodule

/* rtl/plst_queue.sv */
`timescale 1ns / 1ps
module plst_queue
  import plst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output q_stat_t stat,
  output cmd_t    head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.valid = (fill_r != 2'd0);
  assign stat.full  = (fill_r == 2'd2);

endmodule

/* rtl/plst_back.sv */
`timescale 1ns / 1ps
module plst_back
  import plst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      cmd,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_res
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic signed [31:0] store_mem [CAPACITY];
  logic signed [31:0] mem_q_r;

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      w_r, w_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_res_r, out_res_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;

  logic [AW-1:0]      ins_idx;
  logic [AW-1:0]      del_idx;
  logic [POS_W:0]     pos_ext;
  logic [POS_W:0]     cnt_ext;
  logic [CNT_W-1:0]   w_plus1;

  always_comb begin
    pos_ext = {1'b0, cmd.position};
    cnt_ext = (POS_W+1)'(cnt_r);
    w_plus1 = CNT_W'(w_r) + CNT_W'(1);
    case (cmd.where)
      AT_TAIL: ins_idx = cnt_r[AW-1:0];
      AT_HEAD: ins_idx = '0;
      default: ins_idx = AW'(cmd.position - POS_W'(1));
    endcase
    case (cmd.where)
      AT_TAIL: del_idx = AW'(cnt_r - CNT_W'(1));
      AT_HEAD: del_idx = '0;
      default: del_idx = AW'(cmd.position - POS_W'(1));
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = w_r;
    mem_wdata     = mem_q_r;
    mem_raddr     = w_r;
    pop           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_stat.valid) begin
          pop                          = 1'b1;
          out_res_nxt.status           = ST_OK;
          out_res_nxt.element          = '0;
          out_res_nxt.element_position = '0;
          out_res_nxt.count            = cnt_r;
          out_res_nxt.last             = 1'b1;
          case (cmd.op)
            OP_INSERT: begin
              if (cmd.where == AT_POS &&
                  (cmd.position == '0 || pos_ext > cnt_ext + (POS_W+1)'(1))) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = ST_BADPOS;
              end else if (cnt_r >= CAP_C) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = ST_FULL;
              end else begin
                // start shifting from the tail toward the insert point
                mem_raddr = AW'(cnt_r - CNT_W'(1));
                w_nxt     = cnt_r[AW-1:0];
                idx_nxt   = ins_idx;
                val_nxt   = cmd.value;
                state_nxt = S_INS;
              end
            end
            OP_DELETE: begin
              if (cmd.where == AT_POS &&
                  (cmd.position == '0 || pos_ext > cnt_ext)) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = ST_BADPOS;
              end else if (cnt_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = ST_EMPTY;
              end else begin
                mem_raddr = del_idx + AW'(1);
                w_nxt     = del_idx;
                state_nxt = S_DEL;
              end
            end
            OP_READ: begin
              if (cnt_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = ST_EMPTY;
              end else begin
                mem_raddr = '0;
                w_nxt     = '0;
                state_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_res_nxt.status = ST_BADPOS;
            end
          endcase
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = w_r;
        if (w_r == idx_r) begin
          mem_wdata                    = val_r;
          cnt_nxt                      = cnt_r + CNT_W'(1);
          out_valid_nxt                = 1'b1;
          out_res_nxt.status           = ST_OK;
          out_res_nxt.element          = '0;
          out_res_nxt.element_position = '0;
          out_res_nxt.count            = cnt_r + CNT_W'(1);
          out_res_nxt.last             = 1'b1;
          state_nxt                    = S_IDLE;
        end else begin
          mem_wdata = mem_q_r;
          mem_raddr = w_r - AW'(2);
          w_nxt     = w_r - AW'(1);
        end
      end

      S_DEL: begin
        if (w_plus1 == cnt_r) begin
          cnt_nxt                      = cnt_r - CNT_W'(1);
          out_valid_nxt                = 1'b1;
          out_res_nxt.status           = ST_OK;
          out_res_nxt.element          = '0;
          out_res_nxt.element_position = '0;
          out_res_nxt.count            = cnt_r - CNT_W'(1);
          out_res_nxt.last             = 1'b1;
          state_nxt                    = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = w_r;
          mem_wdata = mem_q_r;
          mem_raddr = w_r + AW'(2);
          w_nxt     = w_r + AW'(1);
        end
      end

      S_READ: begin
        out_valid_nxt                = 1'b1;
        out_res_nxt.status           = ST_OK;
        out_res_nxt.element          = mem_q_r;
        out_res_nxt.element_position = w_plus1;
        out_res_nxt.count            = cnt_r;
        out_res_nxt.last             = (w_plus1 == cnt_r);
        mem_raddr                    = w_r + AW'(1);
        w_nxt                        = w_r + AW'(1);
        if (w_plus1 == cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= store_mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* tb/list_store_checker.sv */
`timescale 1ns / 1ps
module list_store_checker
  import plst_pkg::*;
#(
  parameter int CAP = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_cmd,
  input  logic      out_valid,
  input  out_word_t out_res,
  output int        errors,
  output int        pending,
  output int        list_len
);

  // shadow copy of the list, head at index 0
  logic signed [31:0] slots [CAP];
  int                 len;
  out_word_t          list_replies [$];

  initial begin
    errors   = 0;
    pending  = 0;
    list_len = 0;
    len      = 0;
  end

  function automatic out_word_t reply(logic [1:0] st, logic signed [31:0] elem, int epos,
                                      logic fin);
    out_word_t r;
    r.status           = st;
    r.element          = elem;
    r.element_position = epos[6:0];
    r.count            = len[6:0];
    r.last             = fin;
    return r;
  endfunction

  task automatic insert_slot(int idx, logic signed [31:0] v);
    for (int i = len; i > idx; i--) slots[i] = slots[i-1];
    slots[idx] = v;
    len++;
  endtask

  task automatic remove_slot(int idx);
    for (int i = idx; i + 1 < len; i++) slots[i] = slots[i+1];
    len--;
  endtask

  task automatic apply_list_command(in_word_t w);
    logic [1:0] st;
    int         pos;
    pos = w.position;
    st  = ST_OK;
    case (w.action)
      ACT_INS_TAIL, ACT_INS_HEAD: begin
        if (len >= CAP) st = ST_FULL;
        else insert_slot((w.action == ACT_INS_TAIL) ? len : 0, w.value);
      end
      ACT_INS_POS: begin
        // position check wins over the full check
        if (pos < 1 || pos > len + 1) st = ST_BADPOS;
        else if (len >= CAP) st = ST_FULL;
        else insert_slot(pos - 1, w.value);
      end
      ACT_DEL_TAIL, ACT_DEL_HEAD: begin
        if (len == 0) st = ST_EMPTY;
        else remove_slot((w.action == ACT_DEL_TAIL) ? len - 1 : 0);
      end
      ACT_DEL_POS: begin
        if (pos < 1 || pos > len) st = ST_BADPOS;
        else remove_slot(pos - 1);
      end
      ACT_READ: begin
        if (len == 0) list_replies.push_back(reply(ST_EMPTY, '0, 0, 1'b1));
        for (int i = 0; i < len; i++)
          list_replies.push_back(reply(ST_OK, slots[i], i + 1, i == len - 1));
        return;
      end
      default: st = ST_BADPOS;
    endcase
    list_replies.push_back(reply(st, '0, 0, 1'b1));
  endtask

  task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      len = 0;
      list_replies.delete();
    end else begin
      // results first: a word accepted at this edge cannot answer yet
      if (out_valid) begin
        if (list_replies.size() == 0) begin
          $error("result word with nothing owed: %p", out_res);
          errors++;
        end else begin
          want = list_replies.pop_front();
          check_field("status", want.status, out_res.status);
          check_field("element", want.element, out_res.element);
          check_field("element_position", want.element_position, out_res.element_position);
          check_field("count", want.count, out_res.count);
          check_field("last", want.last, out_res.last);
        end
      end
      if (start && !busy) apply_list_command(in_cmd);
    end
    pending  = list_replies.size();
    list_len = len;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import plst_pkg::*;

  // action 7 has no meaning, the block answers it with a bad-position status
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int         CAP        = CAPACITY_DEF;

  // how the random phases lean between growing and shrinking the list
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic      clk    = 1'b0;
  logic      rst_n  = 1'b0;
  logic      start  = 1'b0;
  in_word_t  in_cmd = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_res;
  int        errors;
  int        pending;
  int        list_len;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_store_unit #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_cmd   (in_cmd),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // predicts every result word from the accepted commands and compares it
  list_store_checker #(
    .CAP(CAP)
  ) u_list_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_cmd   (in_cmd),
    .out_valid(out_valid),
    .out_res  (out_res),
    .errors   (errors),
    .pending  (pending),
    .list_len (list_len)
  );

  function automatic in_word_t make_word(logic [2:0] act, logic [7:0] pos, logic [31:0] val);
    in_word_t w;
    w.action   = act;
    w.position = pos;
    w.value    = val;
    return w;
  endfunction

  // mostly legal positions, some just past either end, some anywhere in the field
  function automatic logic [7:0] pick_position(logic [2:0] act, int len);
    int r;
    r = $urandom_range(0, 99);
    if (act == ACT_INS_POS) begin
      if (r < 80) return 8'($urandom_range(1, len + 1));
      if (r < 88) return 8'(len + 2);
    end else if (act == ACT_DEL_POS) begin
      if (r < 80 && len > 0) return 8'($urandom_range(1, len));
      if (r < 84) return 8'(len + 1);
      if (r < 88) return 8'd0;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // extremes now and then, otherwise any 32-bit pattern
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(mix_t mix);
    int r;
    int ins_top;
    int del_top;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins_top = 78;
        del_top = 88;
      end
      MIX_DRAIN: begin
        ins_top = 15;
        del_top = 85;
      end
      default: begin
        ins_top = 45;
        del_top = 85;
      end
    endcase
    if (r < ins_top) begin
      case ($urandom_range(0, 2))
        0:       return ACT_INS_TAIL;
        1:       return ACT_INS_HEAD;
        default: return ACT_INS_POS;
      endcase
    end else if (r < del_top) begin
      case ($urandom_range(0, 2))
        0:       return ACT_DEL_TAIL;
        1:       return ACT_DEL_HEAD;
        default: return ACT_DEL_POS;
      endcase
    end else if (r < 97) begin
      return ACT_READ;
    end
    return ACT_UNUSED;
  endfunction

  // entered at a falling edge, returns at the falling edge after the word is taken;
  // start stays high across back-to-back words
  task automatic send_word(int gap, in_word_t w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_cmd <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off the sender until every owed result word has come back
  task automatic wait_quiet();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    in_word_t   plan [$];
    mix_t       mix;
    logic [2:0] act;

    // synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-list cases, bad positions at both ends, value extremes,
    // inserts and deletes at head, middle and tail, unused action code
    plan.push_back(make_word(ACT_READ,     8'd0,   32'h0));          // read-out of empty list
    plan.push_back(make_word(ACT_DEL_TAIL, 8'd0,   32'h0));          // delete from empty list
    plan.push_back(make_word(ACT_DEL_HEAD, 8'd0,   32'h0));
    plan.push_back(make_word(ACT_DEL_POS,  8'd1,   32'h0));          // bad position on empty list
    plan.push_back(make_word(ACT_INS_POS,  8'd0,   32'h1234_5678));  // position zero
    plan.push_back(make_word(ACT_INS_POS,  8'd2,   32'h1234_5678));  // one past count+1
    plan.push_back(make_word(ACT_INS_TAIL, 8'd255, 32'h7fff_ffff));
    plan.push_back(make_word(ACT_INS_HEAD, 8'd0,   32'h8000_0000));
    plan.push_back(make_word(ACT_INS_POS,  8'd3,   32'hffff_ffff));  // at count+1, i.e. tail
    plan.push_back(make_word(ACT_INS_POS,  8'd2,   32'h0000_0000));  // middle
    plan.push_back(make_word(ACT_INS_POS,  8'd255, 32'ha5a5_a5a5));  // top of the field
    plan.push_back(make_word(ACT_READ,     8'd0,   32'h0));
    plan.push_back(make_word(ACT_UNUSED,   8'd255, 32'hffff_ffff));
    plan.push_back(make_word(ACT_DEL_POS,  8'd5,   32'h0));          // one past count
    plan.push_back(make_word(ACT_DEL_POS,  8'd0,   32'h0));
    plan.push_back(make_word(ACT_DEL_POS,  8'd4,   32'h0));          // tail by position
    plan.push_back(make_word(ACT_DEL_POS,  8'd2,   32'h0));          // middle
    plan.push_back(make_word(ACT_READ,     8'd0,   32'h0));
    plan.push_back(make_word(ACT_DEL_POS,  8'd1,   32'h0));          // head by position
    plan.push_back(make_word(ACT_DEL_HEAD, 8'd0,   32'h0));
    plan.push_back(make_word(ACT_DEL_TAIL, 8'd0,   32'h0));          // delete from empty list again
    plan.push_back(make_word(ACT_INS_HEAD, 8'd0,   32'h5a5a_5a5a));
    foreach (plan[i]) send_word($urandom_range(0, 11), plan[i]);
    wait_quiet();

    // random phases: fill to capacity and beyond, churn, drain past empty
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      repeat (58) begin
        act = pick_action(mix);
        send_word($urandom_range(0, 11),
                  make_word(act, pick_position(act, list_len), pick_value()));
      end
      if (p % 2 == 1) wait_quiet();
    end
    start <= 1'b0;

    // let the last answers drain, then leave room for any stray word
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, roughly twenty times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* positional_list_store_unit.f */
rtl/plst_pkg.sv
rtl/plst_front.sv
rtl/plst_queue.sv
rtl/plst_back.sv
rtl/positional_list_store_unit.sv
tb/list_store_checker.sv
tb/testbench.sv
